// File: design/scl_pkg.sv
// Shared types and constants for the shell command lexer.
// Used by the lexer front, the result queue, the serialiser and the top level.
package scl_pkg;

  // Results one byte can raise, and depth of the queue of result groups
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // Result kinds
  typedef enum logic [2:0] {
    KIND_WORD_BYTE = 3'd0,
    KIND_WORD_END  = 3'd1,
    KIND_SINGLE_OP = 3'd2,
    KIND_DOUBLE_OP = 3'd3,
    KIND_UNMATCHED = 3'd4,
    KIND_LINE_END  = 3'd5
  } kind_t;

  // Quoting modes
  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } quote_mode_t;

  // Character codes
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Group of results raised by one input item
  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    kind_t [MAX_RESULTS-1:0]          kinds;
    logic  [MAX_RESULTS-1:0][7:0]     bytes;
  } bundle_t;

  // Queue head as seen by the serialiser
  typedef struct packed {
    logic    empty;
    bundle_t head;
  } q_head_t;

endpackage

// File: design/scl_front.sv
// Lexer front: accepts bytes, tracks quoting/escape/operator state and
// builds the group of results for each item. Depends on scl_pkg.
module scl_front
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       line_last,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_bundle
);

  typedef struct packed {
    quote_mode_t qm;
    logic        word_open;
    logic        escape_pending;
    logic        operator_pending;
    logic [7:0]  op_char;
  } lex_t;

  typedef struct packed {
    lex_t    st;
    bundle_t res;
  } work_t;

  localparam lex_t LEX_RESET = '{qm: QM_NONE, word_open: 1'b0, escape_pending: 1'b0,
                                 operator_pending: 1'b0, op_char: 8'h00};

  // Append one result while room remains
  function automatic work_t put(work_t w, kind_t k, logic [7:0] b);
    work_t r;
    r = w;
    if (w.res.count < CNT_W'(MAX_RESULTS)) begin
      r.res.kinds[w.res.count[IDX_W-1:0]] = k;
      r.res.bytes[w.res.count[IDX_W-1:0]] = b;
      r.res.count = w.res.count + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic work_t put_byte(work_t w, logic [7:0] b);
    work_t r;
    r = put(w, KIND_WORD_BYTE, b);
    r.st.word_open = 1'b1;
    return r;
  endfunction

  function automatic work_t close_word(work_t w);
    work_t r;
    r = w;
    if (w.st.word_open) begin
      r = put(w, KIND_WORD_END, 8'h00);
      r.st.word_open = 1'b0;
    end
    return r;
  endfunction

  // Byte outside quotes with no escape or operator waiting
  function automatic work_t plain_byte(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_SPACE || c == CH_TAB) begin
      r = close_word(w);
    end else if (c == CH_SQUOTE) begin
      r.st.qm = QM_SINGLE;
      r.st.word_open = 1'b1;
    end else if (c == CH_DQUOTE) begin
      r.st.qm = QM_DOUBLE;
      r.st.word_open = 1'b1;
    end else if (c == CH_PIPE || c == CH_GT || c == CH_AMP) begin
      r = close_word(w);
      r.st.operator_pending = 1'b1;
      r.st.op_char = c;
    end else if (c == CH_LT || c == CH_SEMI) begin
      r = close_word(w);
      r = put(r, KIND_SINGLE_OP, c);
    end else if (c == CH_BSLASH) begin
      r.st.escape_pending = 1'b1;
    end else begin
      r = put_byte(w, c);
    end
    return r;
  endfunction

  function automatic work_t take_byte(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (w.st.qm == QM_SINGLE) begin
      if (c == CH_SQUOTE) r.st.qm = QM_NONE;
      else                r = put_byte(w, c);
    end else if (w.st.qm == QM_DOUBLE) begin
      if (w.st.escape_pending) begin
        r.st.escape_pending = 1'b0;
        if (c != CH_DQUOTE && c != CH_BSLASH) r = put_byte(r, CH_BSLASH);
        r = put_byte(r, c);
      end else if (c == CH_BSLASH) begin
        r.st.escape_pending = 1'b1;
      end else if (c == CH_DQUOTE) begin
        r.st.qm = QM_NONE;
      end else begin
        r = put_byte(w, c);
      end
    end else if (w.st.escape_pending) begin
      r.st.escape_pending = 1'b0;
      r = put_byte(r, c);
    end else if (w.st.operator_pending) begin
      r.st.operator_pending = 1'b0;
      if (c == w.st.op_char) begin
        r = put(r, KIND_DOUBLE_OP, c);
      end else begin
        r = put(r, KIND_SINGLE_OP, w.st.op_char);
        r = plain_byte(r, c);
      end
    end else begin
      r = plain_byte(w, c);
    end
    return r;
  endfunction

  // Flush held state at line end, or flag an open quote
  function automatic work_t end_line(work_t w);
    work_t r;
    r = w;
    if (w.st.qm != QM_NONE) begin
      r = put(w, KIND_UNMATCHED, 8'h00);
    end else begin
      if (r.st.escape_pending)   r = put_byte(r, CH_BSLASH);
      if (r.st.operator_pending) r = put(r, KIND_SINGLE_OP, r.st.op_char);
      r = close_word(r);
      r = put(r, KIND_LINE_END, 8'h00);
    end
    return r;
  endfunction

  lex_t  state;
  lex_t  state_next;
  work_t work;
  logic  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the offered byte against the current state
  always_comb begin
    work.st        = state;
    work.res.count = '0;
    work.res.kinds = '{default: KIND_WORD_BYTE};
    work.res.bytes = '0;
    work = take_byte(work, char_byte);
    if (line_last) begin
      work = end_line(work);
      work.st = LEX_RESET;
    end
    state_next = work.st;
  end

  assign push        = accept && (work.res.count != '0);
  assign push_bundle = work.res;

  // Advance the lexer state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LEX_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && line_last) |=> (state.qm == QM_NONE && !state.word_open &&
                               !state.escape_pending && !state.operator_pending))
    else $error("lexer state not cleared after line end");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_bundle.count <= CNT_W'(MAX_RESULTS)))
    else $error("result group larger than allowed");

endmodule

// File: design/scl_queue.sv
// Short queue of result groups between the lexer front and the serialiser.
// Depends on scl_pkg for the group type.
module scl_queue
  import scl_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output logic    full,
  output q_head_t q_head
);

  localparam int PTR_W  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FILL_W = $clog2(Depth + 1);

  bundle_t            mem [Depth];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full         = (fill == FILL_W'(Depth));
  assign q_head.empty = (fill == '0);
  assign q_head.head  = mem[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_bundle;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_head.empty)
    else $error("pop from empty queue");

endmodule

// File: design/scl_back.sv
// Serialiser: hands out the results of the queue head one per cycle while
// out_ready is high, marking the last of each group. Depends on scl_pkg.
module scl_back
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] byte_out,
  output logic       run_last
);

  logic [IDX_W-1:0] idx;
  logic             out_accept;

  assign out_valid  = !q_head.empty;
  assign kind       = q_head.head.kinds[idx];
  assign byte_out   = q_head.head.bytes[idx];
  assign run_last   = (CNT_W'(idx) == q_head.head.count - CNT_W'(1));
  assign out_accept = out_valid && out_ready;
  assign pop        = out_accept && run_last;

  // Step through the group; restart at the next one after its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_accept) begin
      idx <= run_last ? '0 : idx + IDX_W'(1);
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(idx) < q_head.head.count))
    else $error("result index beyond group size");

endmodule

// File: design/shell_command_lexer.sv
// Shell command lexer top level: lexer front, group queue and serialiser.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
//
// Input channel (in_valid/in_ready): one byte of a command line per item,
// with line_last set on the final byte. Output channel (out_valid/out_ready):
// one token result per item: kind, byte_out and run_last, which marks the
// last result raised by an input byte. A byte may raise no result (opening
// quote, backslash, held | > &, blank outside a word) or up to four.
// A byte's results are registered in the queue when the byte is taken and
// offered once their group reaches its head. Throughput: one byte per cycle
// on the input while the queue is not full; the output gives one result per
// cycle while out_ready is high, giving a byte's results in turn. The queue
// holds QueueDepth result groups; in_ready drops only when it is full, so a
// stalled receiver holds input off after that many groups and nothing is lost.
// Reset (rst, synchronous) clears the lexer state and empties the queue;
// the first byte after reset starts a new line. Every line end also returns
// the lexer to its reset state.
module shell_command_lexer
  import scl_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       line_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] byte_out,
  output logic       run_last
);

  logic    q_full;
  logic    push;
  logic    pop;
  bundle_t push_bundle;
  q_head_t q_head;

  // Classify bytes
  scl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_byte   (char_byte),
    .line_last   (line_last),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // Buffer result groups
  scl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .full        (q_full),
    .q_head      (q_head)
  );

  // Serialise results
  scl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .byte_out  (byte_out),
    .run_last  (run_last)
  );

endmodule
